// File: rtl/pfc_pkg.sv
// Shared types, constants and helpers of the Playfair digraph cipher.
package pfc_pkg;

  localparam int unsigned SIDE = 5;

  typedef logic [4:0] letter_t;
  typedef letter_t [SIDE-1:0] row_t;
  typedef row_t [SIDE-1:0] square_t;
  typedef logic [2:0] pos_t;

  typedef struct packed {
    logic    found;
    pos_t    row;
    pos_t    col;
    letter_t letter;
  } loc_t;

  localparam letter_t LETTER_PAD = 5'd0;
  localparam letter_t LETTER_I   = 5'd8;
  localparam letter_t LETTER_J   = 5'd9;

  localparam logic [2:0] REG_ROW_0   = 3'd0;
  localparam logic [2:0] REG_ROW_1   = 3'd1;
  localparam logic [2:0] REG_ROW_2   = 3'd2;
  localparam logic [2:0] REG_ROW_3   = 3'd3;
  localparam logic [2:0] REG_ROW_4   = 3'd4;
  localparam logic [2:0] REG_DECRYPT = 3'd5;

  localparam logic [24:0] ROW_0_RESET = 25'd4294688;
  localparam logic [24:0] ROW_1_RESET = 25'd10755269;
  localparam logic [24:0] ROW_2_RESET = 25'd16201099;
  localparam logic [24:0] ROW_3_RESET = 25'd21613104;
  localparam logic [24:0] ROW_4_RESET = 25'd27025109;

  // Step one place around the square, forward to encrypt, back to decrypt.
  function automatic pos_t step_pos(input pos_t v, input logic decrypt);
    pos_t r;
    if (decrypt) begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: rtl/pfc_lane.sv
// Lane that finds one letter's row and column in the key square.
module pfc_lane (
  input  pfc_pkg::square_t square,
  input  pfc_pkg::letter_t letter,
  output pfc_pkg::loc_t    loc
);

  always_comb begin
    loc.found  = 1'b0;
    loc.row    = 3'd0;
    loc.col    = 3'd0;
    loc.letter = letter;
    // later matches win: highest row, then highest column
    for (int r = 0; r < pfc_pkg::SIDE; r++) begin
      for (int c = 0; c < pfc_pkg::SIDE; c++) begin
        if (square[r][c] == letter) begin
          loc.found = 1'b1;
          loc.row   = 3'(r);
          loc.col   = 3'(c);
        end
      end
    end
  end

endmodule

// File: rtl/pfc_merge.sv
// Merge stage: applies the digraph rules to the two lane results.
module pfc_merge (
  input  pfc_pkg::square_t square,
  input  logic             decrypt,
  input  pfc_pkg::loc_t    loc_a,
  input  pfc_pkg::loc_t    loc_b,
  output pfc_pkg::letter_t out_first,
  output pfc_pkg::letter_t out_second,
  output logic             letter_missing
);

  pfc_pkg::pos_t ra, ca, rb, cb;
  logic          same_row, same_col;

  assign same_row = (loc_a.row == loc_b.row);
  assign same_col = (loc_a.col == loc_b.col);
  assign letter_missing = !loc_a.found || !loc_b.found;

  always_comb begin
    ra = loc_a.row;
    ca = loc_a.col;
    rb = loc_b.row;
    cb = loc_b.col;
    if (same_row && !same_col) begin
      ca = pfc_pkg::step_pos(loc_a.col, decrypt);
      cb = pfc_pkg::step_pos(loc_b.col, decrypt);
    end else if (same_col && !same_row) begin
      ra = pfc_pkg::step_pos(loc_a.row, decrypt);
      rb = pfc_pkg::step_pos(loc_b.row, decrypt);
    end else if (!same_row && !same_col) begin
      ca = loc_b.col;
      cb = loc_a.col;
    end
  end

  always_comb begin
    if (letter_missing || (same_row && same_col)) begin
      out_first  = loc_a.letter;
      out_second = loc_b.letter;
    end else begin
      out_first  = square[ra][ca];
      out_second = square[rb][cb];
    end
  end

endmodule

// File: rtl/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: two lookup lanes and a merge stage.
// Two register stages: the lane registers (loc_a, loc_b), then the output register (m_tdata).
// Throughput: one digraph per cycle unless the output stalls; each stage holds one item.
// Stalls propagate back through the stage registers to s_tready.
// Reset clears both stage valids, loads the alphabet square without J and selects encrypt.
module playfair_digraph_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // first_letter[4:0], second_letter[9:5], second_present[10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_first[4:0], out_second[9:5], letter_missing[10]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  pfc_pkg::square_t square;
  logic             decrypt;

  pfc_pkg::letter_t in_a, in_b;
  pfc_pkg::loc_t    lane_a, lane_b;
  pfc_pkg::loc_t    loc_a, loc_b;
  logic             lane_valid;
  logic             lane_ready;
  logic             out_ready;

  pfc_pkg::letter_t mrg_first, mrg_second;
  logic             mrg_missing;

  always_ff @(posedge clk) begin
    if (rst) begin
      square[0] <= pfc_pkg::ROW_0_RESET;
      square[1] <= pfc_pkg::ROW_1_RESET;
      square[2] <= pfc_pkg::ROW_2_RESET;
      square[3] <= pfc_pkg::ROW_3_RESET;
      square[4] <= pfc_pkg::ROW_4_RESET;
      decrypt   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pfc_pkg::REG_ROW_0:   square[0] <= cfg_data;
        pfc_pkg::REG_ROW_1:   square[1] <= cfg_data;
        pfc_pkg::REG_ROW_2:   square[2] <= cfg_data;
        pfc_pkg::REG_ROW_3:   square[3] <= cfg_data;
        pfc_pkg::REG_ROW_4:   square[4] <= cfg_data;
        pfc_pkg::REG_DECRYPT: decrypt   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_a = s_tdata[4:0];
    in_b = s_tdata[10] ? s_tdata[9:5] : pfc_pkg::LETTER_PAD;
    if (in_a == pfc_pkg::LETTER_J) begin
      in_a = pfc_pkg::LETTER_I;
    end
    if (in_b == pfc_pkg::LETTER_J) begin
      in_b = pfc_pkg::LETTER_I;
    end
  end

  pfc_lane u_lane_a (.square(square), .letter(in_a), .loc(lane_a));
  pfc_lane u_lane_b (.square(square), .letter(in_b), .loc(lane_b));

  assign out_ready  = !m_tvalid || m_tready;
  assign lane_ready = !lane_valid || out_ready;
  assign s_tready   = lane_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (lane_ready) begin
      lane_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && s_tvalid) begin
      loc_a <= lane_a;
      loc_b <= lane_b;
    end
  end

  pfc_merge u_merge (
    .square         (square),
    .decrypt        (decrypt),
    .loc_a          (loc_a),
    .loc_b          (loc_b),
    .out_first      (mrg_first),
    .out_second     (mrg_second),
    .letter_missing (mrg_missing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && lane_valid) begin
      m_tdata <= {5'd0, mrg_missing, mrg_second, mrg_first};
    end
  end

endmodule

// File: tb/sv/playfair_digraph_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the Playfair digraph cipher: directed digraphs, then random key squares.
module playfair_digraph_cipher_tb;
  import pfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 120;
  localparam int MAX_REPORTS    = 10;

  localparam logic [24:0] ROW_ALL_ONES = 25'h1FFFFFF;

  localparam letter_t LTR_A    = 5'd0;
  localparam letter_t LTR_B    = 5'd1;
  localparam letter_t LTR_E    = 5'd4;
  localparam letter_t LTR_G    = 5'd6;
  localparam letter_t LTR_K    = 5'd10;
  localparam letter_t LTR_M    = 5'd12;
  localparam letter_t LTR_O    = 5'd14;
  localparam letter_t LTR_R    = 5'd17;
  localparam letter_t LTR_S    = 5'd18;
  localparam letter_t LTR_V    = 5'd21;
  localparam letter_t LTR_Y    = 5'd24;
  localparam letter_t LTR_Z    = 5'd25;
  localparam letter_t CODE_26  = 5'd26;
  localparam letter_t CODE_TOP = 5'd31;

  typedef struct packed {
    logic    present;
    letter_t second;
    letter_t first;
  } digraph_t;

  typedef struct packed {
    logic    missing;
    letter_t second;
    letter_t first;
  } cipher_out_t;

  typedef enum int {KEY_SHUFFLED, KEY_REPEATS, KEY_ZEROS, KEY_ONES, KEY_RAW} key_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // first_letter[4:0], second_letter[9:5], second_present[10]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // out_first[4:0], out_second[9:5], letter_missing[10]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  logic [24:0] key_rows [SIDE] = '{ROW_0_RESET, ROW_1_RESET, ROW_2_RESET, ROW_3_RESET,
                                   ROW_4_RESET};
  logic        decrypt_on = 1'b0;

  digraph_t    digraph_q [$];
  cipher_out_t cipher_q [$];

  int   tx_idle_max = 0;
  int   rx_idle_max = 0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   errors = 0;
  int   quiet_cycles = 0;

  playfair_digraph_cipher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic letter_t key_cell(input int r, input int c);
    return key_rows[r][5*c +: 5];
  endfunction

  function automatic int next_place(input int v);
    return decrypt_on ? (v + 4) % 5 : (v + 1) % 5;
  endfunction

  function automatic cipher_out_t predict_digraph(input digraph_t d);
    letter_t     a, b;
    int          ra, ca, rb, cb, r, c;
    logic        fa, fb;
    cipher_out_t res;
    a = (d.first == LETTER_J) ? LETTER_I : d.first;
    b = d.present ? d.second : LETTER_PAD;
    if (b == LETTER_J) b = LETTER_I;
    fa = 1'b0; fb = 1'b0;
    ra = 0; ca = 0; rb = 0; cb = 0;
    for (r = 0; r < SIDE; r++) begin
      for (c = 0; c < SIDE; c++) begin
        if (key_cell(r, c) == a) begin
          ra = r; ca = c; fa = 1'b1;
        end
        if (key_cell(r, c) == b) begin
          rb = r; cb = c; fb = 1'b1;
        end
      end
    end
    res.missing = !(fa && fb);
    res.first   = a;
    res.second  = b;
    if (!res.missing && !(ra == rb && ca == cb)) begin
      if (ra == rb) begin
        res.first  = key_cell(ra, next_place(ca));
        res.second = key_cell(rb, next_place(cb));
      end else if (ca == cb) begin
        res.first  = key_cell(next_place(ra), ca);
        res.second = key_cell(next_place(rb), cb);
      end else begin
        res.first  = key_cell(ra, cb);
        res.second = key_cell(rb, ca);
      end
    end
    return res;
  endfunction

  function automatic digraph_t random_digraph();
    digraph_t d;
    int       r1, c1, r2, c2;
    r1 = $urandom_range(0, 4);
    c1 = $urandom_range(0, 4);
    r2 = $urandom_range(0, 4);
    c2 = $urandom_range(0, 4);
    case ($urandom_range(0, 4))
      0: r2 = r1;
      1: c2 = c1;
      2: begin
        r2 = r1;
        c2 = c1;
      end
      default: ;
    endcase
    d.first   = key_cell(r1, c1);
    d.second  = key_cell(r2, c2);
    d.present = ($urandom_range(0, 9) != 0);
    if (d.first == LETTER_I && $urandom_range(0, 1) == 1) d.first = LETTER_J;
    if (d.second == LETTER_I && $urandom_range(0, 1) == 1) d.second = LETTER_J;
    if ($urandom_range(0, 4) == 0) d = 11'($urandom());
    return d;
  endfunction

  task automatic queue_digraph(input letter_t first, input letter_t second, input logic present);
    digraph_t d;
    d.present = present;
    d.second  = second;
    d.first   = first;
    digraph_q = {digraph_q, d};
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [24:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_DECRYPT) decrypt_on = value[0];
    else key_rows[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (digraph_q.size() != 0 || s_tvalid || cipher_q.size() != 0);
  endtask

  // Driver: hold the item until taken, then idle for its drawn gap.
  always @(negedge clk) begin
    if (!(s_tvalid && !in_fire)) begin
      if (tx_gap > 0) begin
        s_tvalid <= 1'b0;
        tx_gap--;
      end else if (!rst && digraph_q.size() > 0) begin
        s_tdata  <= {5'b0, digraph_q.pop_front()};
        s_tvalid <= 1'b1;
        tx_gap = $urandom_range(0, tx_idle_max);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: drop m_tready for a randomly drawn wait after each item.
  always @(negedge clk) begin
    if (out_fire) rx_wait = $urandom_range(0, rx_idle_max);
    if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cipher_out_t got, want;
    in_fire  <= s_tvalid && s_tready;
    out_fire <= m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) cipher_q = {cipher_q, predict_digraph(s_tdata[10:0])};
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[10:0];
      if (cipher_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected item: first %0d second %0d missing %0b",
                   got.first, got.second, got.missing);
      end else begin
        want = cipher_q.pop_front();
        if (got.first !== want.first || got.second !== want.second ||
            got.missing !== want.missing) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"mismatch: expected first %0d second %0d missing %0b, ",
                      "got first %0d second %0d missing %0b"},
                     want.first, want.second, want.missing,
                     got.first, got.second, got.missing);
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("playfair_digraph_cipher_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    letter_t     deck [25];
    logic [24:0] rows [SIDE];
    letter_t     swap;
    key_kind_t   kind;
    int          p, r, c, n, j, code;

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    tx_idle_max = 9;
    rx_idle_max = 9;

    // alphabet square, encrypt
    queue_digraph(LTR_A, LTR_Z, 1'b1);
    queue_digraph(LTR_Z, LTR_A, 1'b1);
    queue_digraph(LTR_A, LTR_A, 1'b1);
    queue_digraph(LTR_Z, LTR_Z, 1'b1);
    queue_digraph(LTR_A, LTR_E, 1'b1);
    queue_digraph(LTR_E, LTR_A, 1'b1);
    queue_digraph(LTR_A, LTR_V, 1'b1);
    queue_digraph(LTR_V, LTR_A, 1'b1);
    queue_digraph(LETTER_J, LTR_K, 1'b1);
    queue_digraph(LETTER_J, LTR_Y, 1'b1);
    queue_digraph(LETTER_I, LETTER_J, 1'b1);
    queue_digraph(LTR_B, LTR_Z, 1'b0);
    queue_digraph(LTR_A, CODE_TOP, 1'b0);
    queue_digraph(CODE_26, LTR_A, 1'b1);
    queue_digraph(LTR_A, CODE_TOP, 1'b1);
    queue_digraph(CODE_TOP, LTR_G, 1'b0);
    queue_digraph(LTR_G, LTR_R, 1'b1);
    wait_drained();

    write_reg(REG_DECRYPT, 25'd1);
    queue_digraph(LTR_A, LTR_E, 1'b1);
    queue_digraph(LTR_E, LTR_A, 1'b1);
    queue_digraph(LTR_A, LTR_V, 1'b1);
    queue_digraph(LTR_V, LTR_A, 1'b1);
    queue_digraph(LTR_M, LTR_S, 1'b1);
    queue_digraph(LTR_M, LTR_O, 1'b1);
    queue_digraph(LETTER_J, LETTER_J, 1'b1);
    queue_digraph(LTR_Z, LTR_Z, 1'b0);
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      n = 0;
      for (code = 0; code < 26; code++) begin
        if (letter_t'(code) != LETTER_J) begin
          deck[n] = letter_t'(code);
          n++;
        end
      end
      for (n = 24; n > 0; n--) begin
        j = $urandom_range(0, n);
        swap = deck[n];
        deck[n] = deck[j];
        deck[j] = swap;
      end
      kind = key_kind_t'(p % 5);
      if (kind == KEY_REPEATS) begin
        repeat (3) deck[$urandom_range(0, 24)] = deck[$urandom_range(0, 24)];
      end
      for (r = 0; r < SIDE; r++) begin
        for (c = 0; c < SIDE; c++) rows[r][5*c +: 5] = deck[5*r + c];
        case (kind)
          KEY_ZEROS: rows[r] = '0;
          KEY_ONES:  rows[r] = ROW_ALL_ONES;
          KEY_RAW:   rows[r] = 25'($urandom_range(0, ROW_ALL_ONES));
          default:   ;
        endcase
        write_reg(REG_ROW_0 + 3'(r), rows[r]);
      end
      write_reg(REG_DECRYPT, 25'((p % 4) >= 2));
      tx_idle_max = (p % 3 == 0) ? 0 : 9;
      rx_idle_max = (p % 3 == 1) ? 0 : 9;
      for (n = 0; n < PHASE_ITEMS; n++) digraph_q = {digraph_q, random_digraph()};
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("playfair_digraph_cipher_tb: done, clean");
    end else begin
      $display("playfair_digraph_cipher_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: playfair_digraph_cipher.f
rtl/pfc_pkg.sv
rtl/pfc_lane.sv
rtl/pfc_merge.sv
rtl/playfair_digraph_cipher.sv
tb/sv/playfair_digraph_cipher_tb.sv
